// ----- hw/rtl/xcfr_pkg.sv -----
// Shared types and constants for the XOR-checked frame receiver.
// Used by xcfr_ctrl, xcfr_datapath and xor_checked_frame_receiver; no dependencies.
`default_nettype none

package xcfr_pkg;

   localparam int WORD_W     = 16;
   localparam int PAIR_W     = 32;
   localparam int POS_W      = 7;
   localparam int IDX_W      = 4;
   localparam int FAIL_W     = 16;
   localparam int DATA_WORDS = 13;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DATA_WORDS - 1);
   localparam logic [FAIL_W-1:0] FAIL_MAX  = 16'hFFFF;

   // Learned half-word order per board.
   localparam logic [1:0] ORDER_LOHI    = 2'd0;
   localparam logic [1:0] ORDER_HILO    = 2'd1;
   localparam logic [1:0] ORDER_UNKNOWN = 2'd3;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_JUDGE,
      ST_FETCH,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic take;     // a request is accepted this cycle
      logic judge;    // evaluate checksums of the finished frame
      logic fetch;    // read the pair store at the current index
      logic advance;  // the current response is taken
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_end;  // the accepted request completes a full frame
      logic pass;       // frame passes the checksum (valid in judge)
      logic last_item;  // the presented response is the final one of the frame
   } dp_status_type;

   function automatic logic [PAIR_W-1:0] swap_halves(input logic [PAIR_W-1:0] v);
      return {v[15:0], v[31:16]};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/xor_checked_frame_receiver.sv -----
// Top level of the XOR-checked frame receiver.
// Depends on xcfr_pkg, xcfr_ctrl and xcfr_datapath.
//
//   Channel   Direction  Handshake            Contents
//   req_      in         req_valid/req_stall  board, first, word
//   rsp_      out        rsp_valid/rsp_stall  source_board, kind, index, value,
//                                             failures, last
//   csr_      in         csr_valid/csr_ready  swap_bytes
//
// While a frame is collected, one request word is taken every cycle. The
// cycle after the final word of a frame is spent on the checksum verdict,
// with requests stalled. A good frame then yields thirteen responses, each
// read from the store in a fetch state and then presented in a send state,
// with requests still stalled; a rejected frame yields one response
// after the verdict cycle. Responses are held stable while rsp_stall is high.
// Reset clears the control state, the learned orders and the failure
// counters, and sets swap_bytes; the pair store is not cleared, since every
// full frame writes all thirteen pairs before any are read.
`default_nettype none

module xor_checked_frame_receiver import xcfr_pkg::*; #(
   parameter int FRAME_WORDS   = 66,
   parameter int CHECKED_PAIRS = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_swap_bytes,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_board,
   input  wire logic               req_first,
   input  wire logic [WORD_W-1:0]  req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_source_board,
   output logic                    rsp_kind,
   output logic [IDX_W-1:0]        rsp_index,
   output logic [PAIR_W-1:0]       rsp_value,
   output logic [FAIL_W-1:0]       rsp_failures,
   output logic                    rsp_last
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller sequences collection, verdict and the response drain.
   xcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the sums, the pair store and the per-board state.
   xcfr_datapath #(
      .FRAME_WORDS   (FRAME_WORDS),
      .CHECKED_PAIRS (CHECKED_PAIRS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_swap_bytes   (csr_swap_bytes),
      .req_board        (req_board),
      .req_first        (req_first),
      .req_word         (req_word),
      .rsp_source_board (rsp_source_board),
      .rsp_kind         (rsp_kind),
      .rsp_index        (rsp_index),
      .rsp_value        (rsp_value),
      .rsp_failures     (rsp_failures),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/xcfr_ctrl.sv -----
// Controller state machine of the XOR-checked frame receiver.
// Depends on xcfr_pkg; drives the datapath by command struct only.
`default_nettype none

module xcfr_ctrl import xcfr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output logic               req_stall,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (status.frame_end) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            state_in = status.pass ? ST_FETCH : ST_SEND;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               state_in = status.last_item ? ST_COLLECT : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_COLLECT: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_SEND: begin
            rsp_valid   = 1'b1;
            cmd.advance = !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/xcfr_datapath.sv -----
// Datapath of the XOR-checked frame receiver: word intake, XOR sums, pair store,
// per-board order and failure counters, response registers. Depends on xcfr_pkg.
`default_nettype none

module xcfr_datapath import xcfr_pkg::*; #(
   parameter int FRAME_WORDS   = 66,
   parameter int CHECKED_PAIRS = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_cmd_type       cmd,
   output dp_status_type           status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_swap_bytes,
   input  wire logic               req_board,
   input  wire logic               req_first,
   input  wire logic [WORD_W-1:0]  req_word,
   output logic                    rsp_source_board,
   output logic                    rsp_kind,
   output logic [IDX_W-1:0]        rsp_index,
   output logic [PAIR_W-1:0]       rsp_value,
   output logic [FAIL_W-1:0]       rsp_failures,
   output logic                    rsp_last
);

   localparam logic [POS_W-1:0]   LAST_POS = POS_W'(FRAME_WORDS - 1);
   localparam logic [POS_W-1:0]   CHK_LO   = POS_W'(2 * CHECKED_PAIRS);
   localparam logic [POS_W-1:0]   CHK_HI   = POS_W'(2 * CHECKED_PAIRS + 1);
   localparam logic [POS_W-2:0]   SUM_PAIRS = (POS_W-1)'(CHECKED_PAIRS);
   localparam logic [POS_W-2:0]   STORE_PAIRS = (POS_W-1)'(DATA_WORDS);

   logic                 swap_ff;
   logic                 active_ff;
   logic                 board_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [WORD_W-1:0]    held_ff;
   logic [PAIR_W-1:0]    sum_lo_ff;
   logic [PAIR_W-1:0]    sum_hi_ff;
   logic [PAIR_W-1:0]    check_ff;
   logic [1:0]           order_ff [2];
   logic [FAIL_W-1:0]    fail_ff [2];
   logic [PAIR_W-1:0]    store [DATA_WORDS];
   logic [PAIR_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 reject_ff;
   logic                 use_swap_ff;
   logic [FAIL_W-1:0]    fails_out_ff;

   logic [WORD_W-1:0]    w;
   logic                 live;
   logic [POS_W-1:0]     p;
   logic [WORD_W-1:0]    held_base;
   logic [PAIR_W-1:0]    sum_lo_base;
   logic [PAIR_W-1:0]    sum_hi_base;
   logic [PAIR_W-1:0]    check_base;
   logic [PAIR_W-1:0]    pv;
   logic [POS_W-2:0]     k;
   logic                 odd_pos;
   logic                 store_wr;

   logic [1:0]           ord;
   logic [1:0]           new_ord;
   logic                 lohi_ok;
   logic                 hilo_ok;
   logic                 pass;
   logic [FAIL_W-1:0]    fail_cur;
   logic [FAIL_W-1:0]    fail_inc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b1;
      end else if (csr_valid) begin
         swap_ff <= csr_swap_bytes;
      end
   end

   // Word intake. A first word restarts the frame with cleared sums.
   always_comb begin
      w           = swap_ff ? {req_word[7:0], req_word[15:8]} : req_word;
      live        = req_first || active_ff;
      p           = req_first ? '0 : pos_ff;
      held_base   = req_first ? '0 : held_ff;
      sum_lo_base = req_first ? '0 : sum_lo_ff;
      sum_hi_base = req_first ? '0 : sum_hi_ff;
      check_base  = req_first ? '0 : check_ff;
      odd_pos     = p[0];
      k           = p[POS_W-1:1];
      pv          = {w, held_base};
      store_wr    = cmd.take && live && odd_pos && (k < STORE_PAIRS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         board_ff  <= 1'b0;
         pos_ff    <= '0;
         held_ff   <= '0;
         sum_lo_ff <= '0;
         sum_hi_ff <= '0;
         check_ff  <= '0;
      end else if (cmd.take && live) begin
         if (req_first) begin
            board_ff <= req_board;
         end
         if (!odd_pos) begin
            held_ff <= w;
         end else begin
            held_ff <= held_base;
         end
         if (odd_pos && (k < SUM_PAIRS)) begin
            sum_lo_ff <= sum_lo_base ^ pv;
            sum_hi_ff <= sum_hi_base ^ swap_halves(pv);
         end else begin
            sum_lo_ff <= sum_lo_base;
            sum_hi_ff <= sum_hi_base;
         end
         if (p == CHK_LO) begin
            check_ff <= {check_base[31:16], w};
         end else if (p == CHK_HI) begin
            check_ff <= {w, check_base[15:0]};
         end else begin
            check_ff <= check_base;
         end
         if (p == LAST_POS) begin
            active_ff <= 1'b0;
            pos_ff    <= '0;
         end else begin
            active_ff <= 1'b1;
            pos_ff    <= p + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store[k[IDX_W-1:0]] <= pv;
      end
      if (cmd.fetch) begin
         rd_data_ff <= store[idx_ff];
      end
   end

   // Checksum verdict and order learning.
   always_comb begin
      lohi_ok  = (sum_lo_ff == check_ff);
      hilo_ok  = (sum_hi_ff == swap_halves(check_ff));
      ord      = order_ff[board_ff];
      new_ord  = ord;
      if (ord[1]) begin
         if (lohi_ok) begin
            new_ord = ORDER_LOHI;
         end else if (hilo_ok) begin
            new_ord = ORDER_HILO;
         end
      end
      if (new_ord == ORDER_LOHI) begin
         pass = lohi_ok;
      end else if (new_ord == ORDER_HILO) begin
         pass = hilo_ok;
      end else begin
         pass = lohi_ok || hilo_ok;
      end
      fail_cur = fail_ff[board_ff];
      fail_inc = (fail_cur == FAIL_MAX) ? fail_cur : fail_cur + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff[0] <= ORDER_UNKNOWN;
         order_ff[1] <= ORDER_UNKNOWN;
         fail_ff[0]  <= '0;
         fail_ff[1]  <= '0;
         idx_ff      <= '0;
         reject_ff   <= 1'b0;
      end else if (cmd.judge) begin
         order_ff[board_ff] <= new_ord;
         idx_ff             <= '0;
         reject_ff          <= !pass;
         if (pass) begin
            fail_ff[board_ff] <= '0;
         end else begin
            fail_ff[board_ff] <= fail_inc;
         end
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.judge) begin
         use_swap_ff  <= (new_ord == ORDER_HILO);
         fails_out_ff <= pass ? fail_cur : fail_inc;
      end
   end

   always_comb begin
      status.frame_end = cmd.take && live && (p == LAST_POS);
      status.pass      = pass;
      status.last_item = reject_ff || (idx_ff == LAST_IDX);
   end

   assign rsp_source_board = board_ff;
   assign rsp_kind         = reject_ff ? KIND_REJECT : KIND_DATA;
   assign rsp_index        = idx_ff;
   assign rsp_value        = reject_ff   ? '0 :
                             use_swap_ff ? swap_halves(rd_data_ff) : rd_data_ff;
   assign rsp_failures     = fails_out_ff;
   assign rsp_last         = status.last_item;

endmodule

`default_nettype wire

// ----- tb/sv/tb_xor_checked_frame_receiver.sv -----
// Self-checking testbench for the XOR-checked frame receiver: frame words in,
// unpacked words or reject notices out, checked against a local frame tracker.
// Depends on xcfr_pkg and xor_checked_frame_receiver.

module tb_xor_checked_frame_receiver import xcfr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_WORDS   = 66;
   localparam int CHECKED_PAIRS = 14;
   localparam int CHECK_POS     = 2 * CHECKED_PAIRS;  // word position of the check pair
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 40;    // longer than an unstalled unpack drain
   localparam int HOLD_CYCLES   = 400;   // long response hold-off
   localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake at all
   localparam int MAX_REPORTS   = 10;

   // One expected or observed response.
   typedef struct packed {
      logic              source_board;
      logic              kind;
      logic [IDX_W-1:0]  index;
      logic [PAIR_W-1:0] value;
      logic [FAIL_W-1:0] failures;
      logic              last;
   } frame_result_type;

   // Content patterns used to build frames.
   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_BYTES
   } fill_type;

   // How the response side paces itself when no hold-off is running.
   typedef enum logic [1:0] {
      PACE_FREE,
      PACE_LIGHT,
      PACE_PERIODIC,
      PACE_HEAVY
   } rsp_pace_type;

   // Clock, reset and all block inputs start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_valid      = 1'b0;
   logic              csr_swap_bytes = 1'b0;
   logic              csr_ready;
   logic              req_valid      = 1'b0;
   logic              req_board      = 1'b0;
   logic              req_first      = 1'b0;
   logic [WORD_W-1:0] req_word       = '0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic              rsp_source_board;
   logic              rsp_kind;
   logic [IDX_W-1:0]  rsp_index;
   logic [PAIR_W-1:0] rsp_value;
   logic [FAIL_W-1:0] rsp_failures;
   logic              rsp_last;

   always #2 clock = ~clock;

   xor_checked_frame_receiver #(
      .FRAME_WORDS  (FRAME_WORDS),
      .CHECKED_PAIRS(CHECKED_PAIRS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_swap_bytes  (csr_swap_bytes),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_board       (req_board),
      .req_first       (req_first),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_source_board(rsp_source_board),
      .rsp_kind        (rsp_kind),
      .rsp_index       (rsp_index),
      .rsp_value       (rsp_value),
      .rsp_failures    (rsp_failures),
      .rsp_last        (rsp_last)
   );

   // ------------------------------------------------------------------
   // Frame tracker: our own copy of the receiver state. It starts at the
   // values the block takes on reset, since reset is applied only once.
   // ------------------------------------------------------------------
   logic [PAIR_W-1:0] pair_mem [DATA_WORDS];
   logic [PAIR_W-1:0] xor_direct   = '0;  // XOR of pairs taken as hi:lo
   logic [PAIR_W-1:0] xor_swapped  = '0;  // XOR of pairs taken as lo:hi
   logic [WORD_W-1:0] low_half     = '0;  // even word waiting for its partner
   logic [PAIR_W-1:0] check_word   = '0;
   int                frame_pos    = 0;
   logic              in_frame     = 1'b0;
   logic              cur_board    = 1'b0;
   logic [1:0]        learned_order [2] = '{ORDER_UNKNOWN, ORDER_UNKNOWN};
   logic [FAIL_W-1:0] fail_cnt      [2] = '{16'd0, 16'd0};
   logic              swap_en      = 1'b1;

   frame_result_type frame_results_due [$];

   // Run statistics.
   int words_accepted    = 0;
   int stray_words       = 0;
   int frames_good       = 0;
   int frames_rejected   = 0;
   int frames_cut        = 0;
   int results_predicted = 0;
   int responses_checked = 0;
   int csr_writes        = 0;
   int mismatches        = 0;

   // Sender pacing and the response hold-off request.
   int   burst_left     = 0;
   logic sender_gapless = 1'b0;
   int   hold_asked     = 0;

   // Applies one accepted request word to the tracker and queues whatever
   // responses it causes.
   task automatic absorb_word(input logic board, input logic first,
                              input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0] w;
      logic [PAIR_W-1:0] pv;
      logic [FAIL_W-1:0] fails;
      logic              direct_ok;
      logic              swapped_ok;
      logic              frame_ok;
      logic              b;
      int                k;
      frame_result_type  r;

      w = swap_en ? {raw[7:0], raw[15:8]} : raw;

      if (first) begin
         // A first word inside a frame silently drops the partial frame.
         if (in_frame)
            frames_cut++;
         in_frame    = 1'b1;
         cur_board   = board;
         frame_pos   = 0;
         xor_direct  = '0;
         xor_swapped = '0;
         check_word  = '0;
         low_half    = '0;
      end else if (!in_frame) begin
         stray_words++;
         return;
      end

      if (frame_pos % 2 == 0) begin
         low_half = w;
      end else begin
         pv = {w, low_half};
         k  = frame_pos / 2;
         if (k < DATA_WORDS)
            pair_mem[k] = pv;
         if (k < CHECKED_PAIRS) begin
            xor_direct  ^= pv;
            xor_swapped ^= {pv[15:0], pv[31:16]};
         end
      end
      if (frame_pos == CHECK_POS)
         check_word[15:0] = w;
      else if (frame_pos == CHECK_POS + 1)
         check_word[31:16] = w;

      frame_pos++;
      if (frame_pos < FRAME_WORDS)
         return;

      in_frame  = 1'b0;
      frame_pos = 0;
      b         = cur_board;

      direct_ok  = (xor_direct == check_word);
      swapped_ok = (xor_swapped == {check_word[15:0], check_word[31:16]});
      // Any code other than the two learned orders counts as unknown; the
      // first matching frame fixes the order, direct order winning a tie.
      if (learned_order[b] != ORDER_LOHI && learned_order[b] != ORDER_HILO) begin
         if (direct_ok)
            learned_order[b] = ORDER_LOHI;
         else if (swapped_ok)
            learned_order[b] = ORDER_HILO;
      end
      if (learned_order[b] == ORDER_LOHI)
         frame_ok = direct_ok;
      else if (learned_order[b] == ORDER_HILO)
         frame_ok = swapped_ok;
      else
         frame_ok = direct_ok || swapped_ok;

      if (!frame_ok) begin
         if (fail_cnt[b] != FAIL_MAX)
            fail_cnt[b]++;
         r.source_board = b;
         r.kind         = KIND_REJECT;
         r.index        = '0;
         r.value        = '0;
         r.failures     = fail_cnt[b];
         r.last         = 1'b1;
         frame_results_due.push_back(r);
         results_predicted++;
         frames_rejected++;
         return;
      end

      fails       = fail_cnt[b];
      fail_cnt[b] = '0;
      frames_good++;
      for (int i = 0; i < DATA_WORDS; i++) begin
         r.source_board = b;
         r.kind         = KIND_DATA;
         r.index        = IDX_W'(i);
         r.value        = (learned_order[b] == ORDER_HILO) ?
                          {pair_mem[i][15:0], pair_mem[i][31:16]} : pair_mem[i];
         r.failures     = fails;
         r.last         = (i == DATA_WORDS - 1);
         frame_results_due.push_back(r);
         results_predicted++;
      end
   endtask

   // ------------------------------------------------------------------
   // Request side. The caller is always at a rising edge. A gap, if one is
   // due, is taken before the word is offered, so valid is never lowered
   // and raised in the same step. The payload holds while the block stalls.
   // ------------------------------------------------------------------
   task automatic send_word(input logic board, input logic first,
                            input logic [WORD_W-1:0] word);
      if (!sender_gapless && burst_left == 0) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 40);
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      if (burst_left != 0)
         burst_left--;
      req_valid <= 1'b1;
      req_board <= board;
      req_first <= first;
      req_word  <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_accepted++;
      absorb_word(board, first, word);
   endtask

   // Builds one frame in the receiver's byte order and sends its first
   // words_to_send words. The check pair is the XOR of the checked pairs,
   // corrupted on purpose for a bad frame. Words after the first carry a
   // random board, which the block must ignore.
   task automatic send_frame(input logic board, input logic good,
                             input int words_to_send, input fill_type fill);
      logic [WORD_W-1:0] fw [FRAME_WORDS];
      logic [PAIR_W-1:0] sum;
      logic [PAIR_W-1:0] flip;
      logic [WORD_W-1:0] raw;

      for (int i = 0; i < FRAME_WORDS; i++) begin
         case (fill)
            FILL_ZERO:  fw[i] = 16'h0000;
            FILL_ONES:  fw[i] = 16'hFFFF;
            FILL_BYTES: fw[i] = (i % 2 == 0) ? 16'h00FF : 16'hFF00;
            default:    fw[i] = WORD_W'($urandom_range(0, 65535));
         endcase
      end
      sum = '0;
      for (int k = 0; k < CHECKED_PAIRS; k++)
         sum ^= {fw[2*k+1], fw[2*k]};
      if (!good) begin
         flip = $urandom();
         if (flip == '0)
            flip = 32'h8000_0000;
         sum ^= flip;
      end
      fw[CHECK_POS]     = sum[15:0];
      fw[CHECK_POS + 1] = sum[31:16];

      for (int i = 0; i < words_to_send; i++) begin
         raw = swap_en ? {fw[i][7:0], fw[i][15:8]} : fw[i];
         send_word((i == 0) ? board : 1'($urandom_range(0, 1)), i == 0, raw);
      end
   endtask

   // Stops offering requests until every expected response has been taken,
   // then lets the block finish whatever it may still be doing.
   task automatic wait_responses_drained();
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the byte-swap register while the block is idle.
   task automatic write_swap(input logic enable);
      wait_responses_drained();
      csr_valid      <= 1'b1;
      csr_swap_bytes <= enable;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      swap_en = enable;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response side: a pacing pattern of its own, plus a counted hold-off
   // whenever the stimulus asks for one.
   // ------------------------------------------------------------------
   rsp_pace_type rsp_pace   = PACE_FREE;
   int           pace_tick  = 0;
   int           hold_left  = 0;
   int           hold_done  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_pace  <= PACE_FREE;
         pace_tick <= 0;
         hold_left <= 0;
      end else begin
         pace_tick <= pace_tick + 1;
         if (pace_tick % 64 == 63)
            rsp_pace <= rsp_pace_type'($urandom_range(0, 3));
         if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            case (rsp_pace)
               PACE_FREE:     rsp_stall <= 1'b0;
               PACE_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               PACE_PERIODIC: rsp_stall <= (pace_tick % 7 < 3);
               default:       rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Every accepted response is matched against the oldest expectation.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_checked++;
         if (frame_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected response: board %0d kind %0d index %0d value %h",
                        $time, rsp_source_board, rsp_kind, rsp_index, rsp_value);
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_source_board !== want.source_board || rsp_kind !== want.kind ||
                rsp_index !== want.index || rsp_value !== want.value ||
                rsp_failures !== want.failures || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("[%0t] response %0d mismatch", $time, responses_checked);
                  $display("   expected board %0d kind %0d index %0d value %h",
                           want.source_board, want.kind, want.index, want.value);
                  $display("            failures %0d last %0d",
                           want.failures, want.last);
                  $display("   got      board %0d kind %0d index %0d value %h",
                           rsp_source_board, rsp_kind, rsp_index, rsp_value);
                  $display("            failures %0d last %0d",
                           rsp_failures, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no handshake of any kind happens for too
   // long, which covers a hung block as well as lost responses.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d responses still expected",
                     $time, QUIET_LIMIT, frame_results_due.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // A good frame on board 0 with random content; it teaches the board
   // its half-word order.
   task automatic test_good_frames();
      send_frame(1'b0, 1'b1, FRAME_WORDS, FILL_RANDOM);
   endtask

   // A checksum failure on board 1 with all-ones content; the board's
   // failure count goes up and the order stays unknown.
   task automatic test_rejected_frames();
      send_frame(1'b1, 1'b0, FRAME_WORDS, FILL_ONES);
   endtask

   // Byte swapping is turned off; the byte pattern of the next frame
   // shows which way the bytes went.
   task automatic test_byte_swap();
      write_swap(1'b0);
   endtask

   // The response side holds off for a long stretch while the sender keeps
   // offering without gaps, so the block stalls its requests meanwhile.
   // The good frame on board 1 also reports and clears the earlier reject.
   task automatic test_response_hold();
      wait_responses_drained();
      sender_gapless = 1'b1;
      hold_asked <= hold_asked + 1;
      send_frame(1'b1, 1'b1, FRAME_WORDS, FILL_BYTES);
      send_word(1'b0, 1'b0, 16'h5AA5);
      send_word(1'b1, 1'b0, 16'hFFFF);
      sender_gapless = 1'b0;
   endtask

   // Stray words outside a frame are ignored; a first word inside a frame
   // drops the partial frame without any response.
   task automatic test_cut_and_stray_words();
      send_word(1'b0, 1'b0, 16'h0000);
      send_word(1'b1, 1'b0, 16'hA55A);
      send_frame(1'b0, 1'b1, 12, FILL_ZERO);
      send_frame(1'b1, 1'b1, 1, FILL_RANDOM);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_good_frames();
      test_rejected_frames();
      test_byte_swap();
      test_response_hold();
      test_cut_and_stray_words();

      wait_responses_drained();

      $display("Sent %0d request words: %0d good, %0d rejected, %0d cut-off frames,",
               words_accepted, frames_good, frames_rejected, frames_cut);
      $display("%0d stray words; checked %0d responses after %0d byte-swap writes.",
               stray_words, responses_checked, csr_writes);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
